@@ rtl/core/nmea_pkg.sv @@
// Shared types, character codes and tables for the NMEA sentence parser.
package nmea_pkg;

  localparam int MaxFieldChars = 16;
  localparam int CharCntW      = $clog2(MaxFieldChars + 1);

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChPoint  = 8'h2E;

  localparam logic [2:0] TypeUnknown = 3'd0;
  localparam logic [2:0] TypeGsv     = 3'd4;
  localparam int         NumTypes    = 6;

  localparam logic KindField    = 1'b0;
  localparam logic KindSentence = 1'b1;

  // GGA GSA RMC GSV GLL VTG
  localparam logic [23:0] TypeWord [NumTypes] = '{
    24'h474741, 24'h475341, 24'h524D43, 24'h475356, 24'h474C4C, 24'h565447
  };

  typedef struct packed {
    logic step;
    logic clear;
    logic store;
    logic field_zero;
  } scan_ctrl_t;

  typedef struct packed {
    logic [CharCntW-1:0] cnt;
    logic [31:0]         value;
    logic [3:0]          frac;
    logic                stop;
    logic                point;
    logic                neg;
    logic                hexstop;
    logic [7:0]          first;
    logic [7:0]          hex;
    logic [15:0]         recent;
    logic [5:0]          hits;
  } scan_state_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  sentence_type;
    logic [4:0]  field_index;
    logic [31:0] field_value;
    logic [3:0]  frac_digits;
    logic        is_negative;
    logic [7:0]  first_char;
    logic        checksum_ok;
    logic        set_complete;
    logic        unknown_sentence;
  } result_t;

endpackage

@@ rtl/core/nmea_field_scan.sv @@
// Per-field scanner: decimal value, hex checksum digits and field-zero word search.
module nmea_field_scan import nmea_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  scan_ctrl_t  ctrl_i,
  input  logic [7:0]  byte_i,
  output scan_state_t field_o
);

  scan_state_t st_q, st_d, base;
  logic        is_digit;
  logic [3:0]  hex_dig;
  logic        hex_ok;
  logic [35:0] prod;
  logic [23:0] win;

  always_comb begin
    is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);
    hex_ok   = 1'b1;
    hex_dig  = byte_i[3:0];
    if (is_digit) begin
      hex_dig = byte_i[3:0];
    end else if ((byte_i >= 8'h41) && (byte_i <= 8'h46)) begin
      hex_dig = 4'(byte_i - 8'h37);
    end else if ((byte_i >= 8'h61) && (byte_i <= 8'h66)) begin
      hex_dig = 4'(byte_i - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    base = ctrl_i.clear ? '0 : st_q;
    st_d = base;
    prod = ({4'd0, base.value} << 3) + ({4'd0, base.value} << 1) + {32'd0, byte_i[3:0]};
    win  = {base.recent, byte_i};
    if (ctrl_i.store && (base.cnt < CharCntW'(MaxFieldChars))) begin
      if (base.cnt == '0) begin
        st_d.first = byte_i;
      end
      if (!base.stop) begin
        if ((base.cnt == '0) && (byte_i == ChMinus)) begin
          st_d.neg = 1'b1;
        end else if (is_digit) begin
          st_d.value = (|prod[35:32]) ? 32'hFFFF_FFFF : prod[31:0];
          if (base.point && (base.frac != 4'd15)) begin
            st_d.frac = base.frac + 4'd1;
          end
        end else if ((byte_i == ChPoint) && !base.point) begin
          st_d.point = 1'b1;
        end else begin
          st_d.stop = 1'b1;
        end
      end
      if (!base.hexstop) begin
        if (hex_ok) begin
          st_d.hex = {base.hex[3:0], hex_dig};
        end else begin
          st_d.hexstop = 1'b1;
        end
      end
      if (ctrl_i.field_zero) begin
        if (base.cnt >= CharCntW'(2)) begin
          for (int k = 0; k < NumTypes; k++) begin
            if (win == TypeWord[k]) begin
              st_d.hits[k] = 1'b1;
            end
          end
        end
        st_d.recent = win[15:0];
      end
      st_d.cnt = base.cnt + CharCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (ctrl_i.step) begin
      st_q <= st_d;
    end
  end

  assign field_o = st_q;

endmodule

@@ rtl/core/nmea_sent_track.sv @@
// Sentence tracker: checksum, field count, type, GSV paging and the parsed mask.
module nmea_sent_track import nmea_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  scan_state_t field_i,
  output scan_ctrl_t  ctrl_o,
  output logic        has_res_o,
  output result_t     res_o
);

  logic [5:0] en_q;
  logic [7:0] csum_q, csum_d;
  logic       ast_q, ast_d;
  logic [4:0] fcnt_q, fcnt_d;
  logic [2:0] type_q, type_d;
  logic [7:0] ptot_q, ptot_d;
  logic [7:0] pnum_q, pnum_d;
  logic [5:0] mask_q, mask_d;
  logic [5:0] mask_new;
  logic [7:0] page;
  logic [2:0] cls;
  logic       is_dollar, is_end, is_cr, ok, done;

  always_comb begin
    is_dollar = (byte_i == ChDollar);
    is_end    = (byte_i == ChComma) || (byte_i == ChStar);
    is_cr     = (byte_i == ChCr);

    ctrl_o.step       = step_i;
    ctrl_o.clear      = is_dollar || is_end;
    ctrl_o.store      = !is_end && !is_cr;
    ctrl_o.field_zero = is_dollar || (fcnt_q == 5'd0);

    cls = TypeUnknown;
    for (int k = NumTypes - 1; k >= 0; k--) begin
      if (field_i.hits[k]) begin
        cls = 3'(k + 1);
      end
    end
    page = field_i.neg ? 8'(8'd0 - field_i.value[7:0]) : field_i.value[7:0];

    ok       = (field_i.hex == csum_q);
    mask_new = mask_q;
    if ((type_q != TypeUnknown) && ((type_q != TypeGsv) || (pnum_q == ptot_q))) begin
      mask_new = mask_q | (6'd1 << (type_q - 3'd1));
    end
    done = ok && ((mask_new & en_q) == en_q);

    csum_d = csum_q;
    ast_d  = ast_q;
    fcnt_d = fcnt_q;
    type_d = type_q;
    ptot_d = ptot_q;
    pnum_d = pnum_q;
    mask_d = mask_q;
    has_res_o = 1'b0;

    if (is_dollar) begin
      csum_d = '0;
      ast_d  = 1'b0;
      fcnt_d = '0;
      type_d = TypeUnknown;
      ptot_d = '0;
      pnum_d = '0;
    end else if (is_end) begin
      has_res_o = 1'b1;
      if ((fcnt_q == 5'd0) && (field_i.first == ChDollar)) begin
        type_d = cls;
      end else if ((type_q == TypeGsv) && (fcnt_q == 5'd1)) begin
        ptot_d = page;
      end else if ((type_q == TypeGsv) && (fcnt_q == 5'd2)) begin
        pnum_d = page;
      end
      if (byte_i == ChComma) begin
        csum_d = csum_q ^ byte_i;
      end else begin
        ast_d = 1'b1;
      end
      if (fcnt_q != 5'd31) begin
        fcnt_d = fcnt_q + 5'd1;
      end
    end else if (is_cr) begin
      has_res_o = 1'b1;
      if (ok) begin
        mask_d = done ? 6'd0 : mask_new;
      end
    end else if (!ast_q) begin
      csum_d = csum_q ^ byte_i;
    end

    res_o.kind             = is_cr ? KindSentence : KindField;
    res_o.sentence_type    = type_d;
    res_o.field_index      = fcnt_q;
    res_o.field_value      = is_cr ? 32'd0 : field_i.value;
    res_o.frac_digits      = is_cr ? 4'd0 : field_i.frac;
    res_o.is_negative      = is_cr ? 1'b0 : field_i.neg;
    res_o.first_char       = is_cr ? 8'd0 : field_i.first;
    res_o.checksum_ok      = is_cr && ok;
    res_o.set_complete     = is_cr && done;
    res_o.unknown_sentence = is_cr && (type_q == TypeUnknown);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 6'h3F;
      csum_q <= '0;
      ast_q  <= 1'b0;
      fcnt_q <= '0;
      type_q <= TypeUnknown;
      ptot_q <= '0;
      pnum_q <= '0;
      mask_q <= '0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (step_i) begin
        csum_q <= csum_d;
        ast_q  <= ast_d;
        fcnt_q <= fcnt_d;
        type_q <= type_d;
        ptot_q <= ptot_d;
        pnum_q <= pnum_d;
        mask_q <= mask_d;
      end
    end
  end

endmodule

@@ rtl/core/nmea_sentence_parser.sv @@
// Top level of the NMEA sentence parser: input register, scanner, tracker, result register.
//
//   channel   direction  handshake               payload
//   rx        in         rx_valid_i / rx_stall_o rx_byte_i
//   res       out        res_valid_o / res_stall_i result fields
//   cfg       in         cfg_we_i                cfg_wdata_i (enabled sentences)
//
// One byte per cycle sustained while the result side does not stall; a byte is held in the
// input register and its result, if any, is then registered in the result register.
// Reset clears all sentence and field state and enables all six sentence types.
// A stalled result holds the input register, which then stalls the rx side.
module nmea_sentence_parser import nmea_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        result_kind_o,
  output logic [2:0]  sentence_type_o,
  output logic [4:0]  field_index_o,
  output logic [31:0] field_value_o,
  output logic [3:0]  frac_digits_o,
  output logic        is_negative_o,
  output logic [7:0]  first_char_o,
  output logic        checksum_ok_o,
  output logic        set_complete_o,
  output logic        unknown_sentence_o
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_q;
  logic        out_free, advance, rx_take, has_res;
  scan_ctrl_t  ctrl;
  scan_state_t field;
  result_t     res;

  assign out_free   = !out_valid_q || !res_stall_i;
  assign advance    = in_valid_q && out_free;
  assign rx_stall_o = in_valid_q && !out_free;
  assign rx_take    = rx_valid_i && !rx_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance || !in_valid_q) begin
      in_valid_d = rx_valid_i;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = advance && has_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance && has_res) begin
      out_q <= res;
    end
  end

  nmea_field_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .byte_i  (in_byte_q),
    .field_o (field)
  );

  nmea_sent_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .field_i     (field),
    .ctrl_o      (ctrl),
    .has_res_o   (has_res),
    .res_o       (res)
  );

  assign res_valid_o        = out_valid_q;
  assign result_kind_o      = out_q.kind;
  assign sentence_type_o    = out_q.sentence_type;
  assign field_index_o      = out_q.field_index;
  assign field_value_o      = out_q.field_value;
  assign frac_digits_o      = out_q.frac_digits;
  assign is_negative_o      = out_q.is_negative;
  assign first_char_o       = out_q.first_char;
  assign checksum_ok_o      = out_q.checksum_ok;
  assign set_complete_o     = out_q.set_complete;
  assign unknown_sentence_o = out_q.unknown_sentence;

  a_stall_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stall_o |-> (in_valid_q && out_valid_q && res_stall_i))
    else $error("rx stalled without a held byte and a stalled result");

  a_no_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !has_res) |=> !res_valid_o)
    else $error("byte without result left a result valid");

  a_field_flags_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (result_kind_o == KindField))
      |-> (!checksum_ok_o && !set_complete_o && !unknown_sentence_o))
    else $error("field transfer carries sentence-end flags");

  a_complete_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && set_complete_o) |-> checksum_ok_o)
    else $error("update signalled on a bad checksum");

endmodule

@@ test/testbench.sv @@
// Testbench for nmea_sentence_parser: shadow decoder, directed and random NMEA text, random handshakes.
module testbench;
  import nmea_pkg::*;

  class parse_tracker;
    result_t     awaited[$];
    logic [5:0]  enabled;
    logic [7:0]  csum;
    logic        after_star;
    logic [4:0]  field_no;
    int unsigned chars;
    logic [31:0] value;
    logic [3:0]  frac;
    logic        stop, point, neg, hexstop;
    logic [7:0]  first, hex_val;
    logic [15:0] recent;
    logic [5:0]  hits;
    logic [2:0]  cur_type;
    logic [7:0]  page_total, page_number;
    logic [5:0]  parsed;
    int unsigned errors, fields_seen, sentences_seen, good_sums, completions;

    function new();
      restart();
    endfunction

    function void restart();
      enabled = 6'h3F;
      csum = 8'h00;
      after_star = 1'b0;
      field_no = 5'd0;
      cur_type = TypeUnknown;
      page_total = 8'h00;
      page_number = 8'h00;
      parsed = 6'h00;
      clear_field();
    endfunction

    function void clear_field();
      chars = 0;
      value = 32'd0;
      frac = 4'd0;
      stop = 1'b0;
      point = 1'b0;
      neg = 1'b0;
      hexstop = 1'b0;
      first = 8'h00;
      hex_val = 8'h00;
      recent = 16'h0000;
      hits = 6'h00;
    endfunction

    function void store_char(logic [7:0] c);
      logic [63:0] wide;
      logic [23:0] window;
      logic [4:0]  nib;
      if (chars >= MaxFieldChars) return;
      if (chars == 0) first = c;
      if (!stop) begin
        if (chars == 0 && c == ChMinus) begin
          neg = 1'b1;
        end else if (c >= "0" && c <= "9") begin
          wide = 64'(value) * 64'd10 + 64'(c - 8'h30);
          value = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
          if (point && frac < 4'd15) frac++;
        end else if (c == ChPoint && !point) begin
          point = 1'b1;
        end else begin
          stop = 1'b1;
        end
      end
      if (!hexstop) begin
        nib = 5'd16;
        if (c >= "0" && c <= "9") nib = 5'(c - 8'h30);
        else if (c >= "A" && c <= "F") nib = 5'(c - 8'h37);
        else if (c >= "a" && c <= "f") nib = 5'(c - 8'h57);
        if (nib < 5'd16) hex_val = {hex_val[3:0], nib[3:0]};
        else hexstop = 1'b1;
      end
      if (field_no == 5'd0) begin
        window = {recent, c};
        if (chars >= 2)
          for (int k = 0; k < NumTypes; k++)
            if (window == TypeWord[k]) hits[k] = 1'b1;
        recent = window[15:0];
      end
      chars++;
    endfunction

    function void take_byte(logic [7:0] c);
      result_t    r;
      logic [7:0] p;
      r = '0;
      if (c == ChDollar) begin
        after_star = 1'b0;
        field_no = 5'd0;
        cur_type = TypeUnknown;
        csum = 8'h00;
        page_total = 8'h00;
        page_number = 8'h00;
        clear_field();
        store_char(c);
      end else if (c == ChComma || c == ChStar) begin
        if (field_no == 5'd0 && first == ChDollar) begin
          cur_type = TypeUnknown;
          for (int k = NumTypes - 1; k >= 0; k--)
            if (hits[k]) cur_type = 3'(k + 1);
        end else if (cur_type == TypeGsv && (field_no == 5'd1 || field_no == 5'd2)) begin
          p = value[7:0];
          if (neg) p = -p;
          if (field_no == 5'd1) page_total = p;
          else page_number = p;
        end
        r.kind = KindField;
        r.sentence_type = cur_type;
        r.field_index = field_no;
        r.field_value = value;
        r.frac_digits = frac;
        r.is_negative = neg;
        r.first_char = first;
        awaited.push_back(r);
        if (c == ChComma) csum ^= c;
        else after_star = 1'b1;
        clear_field();
        if (field_no < 5'd31) field_no++;
      end else if (c == ChCr) begin
        r.kind = KindSentence;
        r.sentence_type = cur_type;
        r.field_index = field_no;
        r.checksum_ok = (hex_val == csum);
        if (r.checksum_ok) begin
          if (cur_type != TypeUnknown && (cur_type != TypeGsv || page_number == page_total))
            parsed[cur_type - 3'd1] = 1'b1;
          if ((parsed & enabled) == enabled) begin
            parsed = 6'h00;
            r.set_complete = 1'b1;
          end
        end
        r.unknown_sentence = (cur_type == TypeUnknown);
        awaited.push_back(r);
      end else begin
        if (!after_star) csum ^= c;
        store_char(c);
      end
    endfunction

    function string show(result_t r);
      return $sformatf({"kind %0d type %0d field %0d value %0d frac %0d neg %0d",
                        " first 8'h%02h ok %0d set %0d unknown %0d"},
                       r.kind, r.sentence_type, r.field_index, r.field_value, r.frac_digits,
                       r.is_negative, r.first_char, r.checksum_ok, r.set_complete,
                       r.unknown_sentence);
    endfunction

    function void match_report(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want = awaited.pop_front();
      if (want.kind == KindField) begin
        fields_seen++;
      end else begin
        sentences_seen++;
        good_sums += want.checksum_ok;
        completions += want.set_complete;
      end
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch, expected %s", show(want));
          $display("          actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        rx_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        cfg_we_i    = 1'b0;
  logic [5:0]  cfg_wdata_i = 6'h00;
  logic        res_stall_i = 1'b0;
  logic        rx_stall_o;
  logic        res_valid_o;
  logic        result_kind_o;
  logic [2:0]  sentence_type_o;
  logic [4:0]  field_index_o;
  logic [31:0] field_value_o;
  logic [3:0]  frac_digits_o;
  logic        is_negative_o;
  logic [7:0]  first_char_o;
  logic        checksum_ok_o;
  logic        set_complete_o;
  logic        unknown_sentence_o;

  parse_tracker shadow = new();
  logic [7:0]   line_buf[$];
  int unsigned  burst_left = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  settings_used = 0;
  bit           bursty = 1'b1;
  int unsigned  stall_run = 0;
  int unsigned  stall_ticks = 0;
  logic         stall_now = 1'b0;

  nmea_sentence_parser uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .rx_valid_i         (rx_valid_i),
    .rx_stall_o         (rx_stall_o),
    .rx_byte_i          (rx_byte_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .res_valid_o        (res_valid_o),
    .res_stall_i        (res_stall_i),
    .result_kind_o      (result_kind_o),
    .sentence_type_o    (sentence_type_o),
    .field_index_o      (field_index_o),
    .field_value_o      (field_value_o),
    .frac_digits_o      (frac_digits_o),
    .is_negative_o      (is_negative_o),
    .first_char_o       (first_char_o),
    .checksum_ok_o      (checksum_ok_o),
    .set_complete_o     (set_complete_o),
    .unknown_sentence_o (unknown_sentence_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i)
      shadow.match_report({result_kind_o, sentence_type_o, field_index_o, field_value_o,
                           frac_digits_o, is_negative_o, first_char_o, checksum_ok_o,
                           set_complete_o, unknown_sentence_o});
    stall_ticks++;
    if (stall_run == 0) begin
      case ((stall_ticks / 1500) % 4)
        0: begin
          stall_now = 1'b0;
          stall_run = 64;
        end
        1: begin
          stall_now = ($urandom_range(0, 3) == 0);
          stall_run = $urandom_range(1, 3);
        end
        2: begin
          stall_now = !stall_now;
          stall_run = $urandom_range(1, 6);
        end
        default: begin
          stall_now = 1'($urandom_range(0, 1));
          stall_run = 1;
        end
      endcase
    end else begin
      stall_run--;
    end
    res_stall_i <= stall_now;
  end

  task automatic push_byte(logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (bursty) begin
        rx_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    // hold the byte until the transfer completes
    do @(posedge clk_i); while (rx_stall_o);
    shadow.take_byte(b);
    bytes_sent++;
    if (bytes_sent % 300 == 0) bursty = !bursty;
  endtask

  task automatic send_line();
    while (line_buf.size() != 0) push_byte(line_buf.pop_front());
  endtask

  task automatic settle();
    rx_valid_i <= 1'b0;
    for (int n = 0; n < 5000 && shadow.awaited.size() != 0; n++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_enables(logic [5:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow.enabled = v;
    settings_used++;
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void put_digits(int n);
    for (int i = 0; i < n; i++) line_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h57 : 8'h37) + 8'(n);
  endfunction

  function automatic void seal(bit corrupt, bit lower);
    logic [7:0] sum;
    sum = 8'h00;
    for (int i = 1; i < line_buf.size(); i++) sum ^= line_buf[i];
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    line_buf.push_back(ChStar);
    line_buf.push_back(hex_char(sum[7:4], lower));
    line_buf.push_back(hex_char(sum[3:0], lower));
    line_buf.push_back(ChCr);
    line_buf.push_back(8'h0A);
  endfunction

  function automatic void put_field();
    int         n;
    logic [7:0] c;
    string      letters;
    letters = "NSEWAVMTK";
    case ($urandom_range(0, 5))
      0: ;
      1: put_digits($urandom_range(1, 12));
      2: begin
        if ($urandom_range(0, 2) == 0) line_buf.push_back(ChMinus);
        put_digits($urandom_range(0, 5));
        line_buf.push_back(ChPoint);
        put_digits($urandom_range(0, 8));
      end
      3: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) line_buf.push_back(letters[$urandom_range(0, 8)]);
      end
      4: begin
        n = $urandom_range(1, 22);
        for (int i = 0; i < n; i++) begin
          do c = 8'($urandom_range(33, 126));
          while (c == ChDollar || c == ChComma || c == ChStar);
          line_buf.push_back(c);
        end
      end
      default: put_digits($urandom_range(1, 3));
    endcase
  endfunction

  function automatic void put_sentence(int kind, int fields);
    int total;
    int page;
    put_text("$");
    case ($urandom_range(0, 4))
      0: put_text("GP");
      1: put_text("GN");
      2: put_text("GL");
      3: put_text("BD");
      default: begin
        line_buf.push_back(8'($urandom_range(65, 90)));
        line_buf.push_back(8'($urandom_range(65, 90)));
      end
    endcase
    case (kind)
      0: put_text("GGA");
      1: put_text("GSA");
      2: put_text("RMC");
      3: put_text("GSV");
      4: put_text("GLL");
      5: put_text("VTG");
      default: begin
        if ($urandom_range(0, 1)) put_text("ZDA");
        else put_text("TXT");
      end
    endcase
    if ($urandom_range(0, 9) == 0) line_buf.push_back(8'($urandom_range(48, 90)));
    if (kind == 3) begin
      total = $urandom_range(1, 3);
      page = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : $urandom_range(1, total);
      put_text($sformatf(",%0d,%0d", total, page));
    end
    for (int i = 0; i < fields; i++) begin
      line_buf.push_back(ChComma);
      put_field();
    end
  endfunction

  task automatic send_sentence(string body, bit corrupt, bit lower);
    line_buf.delete();
    put_text("$");
    put_text(body);
    seal(corrupt, lower);
    send_line();
  endtask

  task automatic send_raw(string s, bit end_cr);
    line_buf.delete();
    put_text(s);
    if (end_cr) line_buf.push_back(ChCr);
    send_line();
  endtask

  task automatic random_traffic(int unsigned budget);
    int unsigned stop_at;
    int          pick;
    int          total;
    int          idx;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      line_buf.delete();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        put_sentence($urandom_range(0, 6), $urandom_range(0, 8));
        seal($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)));
      end else if (pick < 78) begin
        total = $urandom_range(1, 4);
        for (int p = 1; p <= total; p++) begin
          put_text($sformatf("$GPGSV,%0d,%0d", total, p));
          repeat ($urandom_range(0, 4)) begin
            line_buf.push_back(ChComma);
            put_field();
          end
          seal(1'b0, 1'($urandom_range(0, 1)));
          send_line();
        end
      end else if (pick < 88) begin
        // mangle an otherwise good sentence
        put_sentence($urandom_range(0, 6), $urandom_range(0, 6));
        seal(1'b0, 1'b0);
        idx = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 2))
          0: while (line_buf.size() > idx) void'(line_buf.pop_back());
          1: line_buf[idx] = 8'($urandom_range(0, 255));
          default: line_buf.insert(idx, ChDollar);
        endcase
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        put_sentence($urandom_range(0, 6), $urandom_range(28, 36));
        seal($urandom_range(0, 3) == 0, 1'b0);
      end
      send_line();
    end
  endtask

  initial begin : stimulus
    logic [5:0] plan [8];
    plan = '{6'h3F, 6'h00, 6'h08, 6'h15, 6'h2A, 6'h00, 6'h00, 6'h3F};
    plan[5] = 6'($urandom_range(0, 63));
    plan[6] = 6'($urandom_range(0, 63));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_raw("7.25,-3*", 1'b1);
    send_sentence("GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", 1'b0, 1'b0);
    send_sentence("GPGSA,A,3,04,05,,09,12,,,24,,,,,2.5,1.3,2.1", 1'b0, 1'b1);
    send_sentence("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W",
                  1'b0, 1'b0);
    send_sentence("GPGSV,2,1,08,01,40,083,46", 1'b0, 1'b0);
    send_sentence("GPGSV,2,2,08,02,17,308,41", 1'b0, 1'b0);
    send_sentence("GPGLL,4916.45,N,12311.12,W,225444,A", 1'b0, 1'b0);
    send_sentence("GPVTG,054.7,T,034.4,M,005.5,N,010.2,K", 1'b0, 1'b0);
    send_sentence("GPXYZ,1,2", 1'b0, 1'b0);
    send_sentence("GSAGGA,1", 1'b0, 1'b0);
    send_sentence("ABCDEFGHIJKLMNOPGGA,5", 1'b0, 1'b0);
    send_sentence("GPGGA,99999999999,-12.3456789012345,1.2.3,-,--5,12abc,-.5", 1'b0, 1'b0);
    send_sentence("GPRMC,123456789012345678901,.123456789012345", 1'b0, 1'b1);
    send_sentence("GPGSV,-1,255,1", 1'b0, 1'b0);
    send_sentence("GPGLL,1,2", 1'b1, 1'b0);
    send_raw("$GPGLL,1*3f,7", 1'b1);
    send_raw("$GPRMC,12$GPVTG,3*", 1'b1);
    send_raw("$GPZDA,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,*", 1'b1);
    send_raw("$GPTXT", 1'b1);
    send_raw("", 1'b1);
    send_raw("$GPVTG,1*4G2", 1'b1);

    foreach (plan[i]) begin
      write_enables(plan[i]);
      random_traffic(80);
    end
    settle();

    $display("sent %0d bytes over %0d enable settings: %0d field ends, %0d sentence ends",
             bytes_sent, settings_used, shadow.fields_seen, shadow.sentences_seen);
    $display("%0d sentences passed their checksum, %0d full sets completed",
             shadow.good_sums, shadow.completions);
    if (shadow.errors == 0 && shadow.awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               shadow.errors, shadow.awaited.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", shadow.awaited.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
